// ===== hw/rtl/pcc_pkg.sv =====
package pcc_pkg;

    localparam int unsigned DIST_W = 16;
    localparam int unsigned RATE_W = 16;
    localparam int unsigned COST_W = 17;
    localparam int unsigned OCC_W = 8;
    localparam int unsigned CFG_DATA_W = 17;
    localparam int unsigned CFG_INDEX_W = 3;

    localparam logic [COST_W-1:0] COST_ONE = 17'd65536;
    localparam logic [COST_W-1:0] COST_NEAR_ONE = 17'd65471;
    localparam logic [OCC_W-1:0] OCC_FREE = 8'd255;

    localparam logic [CFG_INDEX_W-1:0] REG_MIN_OBSTACLE_DISTANCE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OBSTACLE_SCALING = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OPTIMAL_VIEW_DISTANCE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_VIEW_SCALING = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_SCALING = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OBSTACLE_WEIGHT = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_VIEW_WEIGHT = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_WEIGHT = 3'd7;

    typedef struct packed {
        logic [DIST_W-1:0] min_obstacle_distance;
        logic [RATE_W-1:0] obstacle_scaling;
        logic [DIST_W-1:0] optimal_view_distance;
        logic [RATE_W-1:0] view_scaling;
        logic [RATE_W-1:0] center_scaling;
        logic [COST_W-1:0] obstacle_weight;
        logic [COST_W-1:0] view_weight;
        logic [COST_W-1:0] center_weight;
    } cfg_t;

endpackage

// ===== hw/rtl/pcc_if.sv =====
interface pcc_pixel_if;
    logic valid;
    logic ready;
    logic [pcc_pkg::OCC_W-1:0] occupancy;
    logic [pcc_pkg::DIST_W-1:0] obstacle_distance;
    logic [pcc_pkg::DIST_W-1:0] skeleton_distance;

    modport source (output valid, occupancy, obstacle_distance, skeleton_distance,
                    input ready);
    modport sink (input valid, occupancy, obstacle_distance, skeleton_distance,
                  output ready);
endinterface

interface pcc_cost_if;
    logic valid;
    logic ready;
    logic [pcc_pkg::COST_W-1:0] obstacle_term;
    logic [pcc_pkg::COST_W-1:0] view_term;
    logic [pcc_pkg::COST_W-1:0] center_term;
    logic [pcc_pkg::COST_W-1:0] combined_cost;
    logic [pcc_pkg::COST_W-1:0] probability;

    modport source (output valid, obstacle_term, view_term, center_term, combined_cost,
                    probability, input ready);
    modport sink (input valid, obstacle_term, view_term, center_term, combined_cost,
                  probability, output ready);
endinterface

// ===== hw/rtl/pcc_cfg_regs.sv =====
module pcc_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [pcc_pkg::CFG_INDEX_W-1:0]     wr_index,
    input  logic [pcc_pkg::CFG_DATA_W-1:0]      wr_data,
    output pcc_pkg::cfg_t                       cfg
);

    pcc_pkg::cfg_t cfg_reg;
    pcc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                pcc_pkg::REG_MIN_OBSTACLE_DISTANCE: cfg_next.min_obstacle_distance = wr_data[15:0];
                pcc_pkg::REG_OBSTACLE_SCALING:      cfg_next.obstacle_scaling = wr_data[15:0];
                pcc_pkg::REG_OPTIMAL_VIEW_DISTANCE: cfg_next.optimal_view_distance = wr_data[15:0];
                pcc_pkg::REG_VIEW_SCALING:          cfg_next.view_scaling = wr_data[15:0];
                pcc_pkg::REG_CENTER_SCALING:        cfg_next.center_scaling = wr_data[15:0];
                pcc_pkg::REG_OBSTACLE_WEIGHT:       cfg_next.obstacle_weight = wr_data;
                pcc_pkg::REG_VIEW_WEIGHT:           cfg_next.view_weight = wr_data;
                pcc_pkg::REG_CENTER_WEIGHT:         cfg_next.center_weight = wr_data;
                default:                            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_obstacle_distance <= 16'd0;
            cfg_reg.obstacle_scaling <= 16'd4096;
            cfg_reg.optimal_view_distance <= 16'd256;
            cfg_reg.view_scaling <= 16'd4096;
            cfg_reg.center_scaling <= 16'd4096;
            cfg_reg.obstacle_weight <= 17'd21845;
            cfg_reg.view_weight <= 17'd21845;
            cfg_reg.center_weight <= 17'd21846;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/pcc_exp_unit.sv =====
module pcc_exp_unit #(
    parameter int unsigned EXP_TABLE_ENTRIES = 256
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic [pcc_pkg::DIST_W-1:0]      distance,
    input  logic [pcc_pkg::RATE_W-1:0]      rate,
    output logic [pcc_pkg::COST_W-1:0]      exp_val
);

    localparam int unsigned IDX_W = (EXP_TABLE_ENTRIES > 1) ? $clog2(EXP_TABLE_ENTRIES) : 1;
    localparam int unsigned PROD_W = pcc_pkg::DIST_W + pcc_pkg::RATE_W;
    localparam int unsigned SCALED_W = PROD_W + 14;
    localparam logic [SCALED_W-1:0] ENTRIES = SCALED_W'(EXP_TABLE_ENTRIES);
    localparam logic [SCALED_W-1:0] HALF_STEP = SCALED_W'(64'd1 << 23);

    // Quotient by shift and subtract; used only while the table is built.
    function automatic longint unsigned div_small(input longint unsigned num,
                                                  input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            if (rem >= den)
            begin
                rem = rem - den;
                q = q | (64'd1 << b);
            end
        end
        return q;
    endfunction

    // exp(-f) for f in [0,1] as Q.30, alternating Taylor series.
    function automatic longint unsigned exp_neg_unit(input longint unsigned f);
        longint sum;
        longint unsigned term;
        longint unsigned k;
        sum = longint'(64'd1 << 30);
        term = 64'd1 << 30;
        for (k = 1; k <= 24; k++)
        begin
            term = div_small((term * f) >> 30, k);
            if (k[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        return longint'(sum);
    endfunction

    function automatic logic [pcc_pkg::COST_W-1:0] exp_entry(input longint unsigned i);
        longint unsigned e1;
        longint unsigned y;
        longint unsigned n;
        longint unsigned r;
        longint unsigned v;
        e1 = exp_neg_unit(64'd1 << 30);
        y = div_small(i << 34, 64'(EXP_TABLE_ENTRIES));
        n = y >> 30;
        r = exp_neg_unit(y & ((64'd1 << 30) - 64'd1));
        while (n > 0)
        begin
            r = (r * e1 + (64'd1 << 29)) >> 30;
            n = n - 1;
        end
        v = (r + 64'd8192) >> 14;
        if (v > 64'd65536)
            v = 64'd65536;
        return v[pcc_pkg::COST_W-1:0];
    endfunction

    logic [pcc_pkg::COST_W-1:0] lut [EXP_TABLE_ENTRIES];

    for (genvar g = 0; g < EXP_TABLE_ENTRIES; g++)
    begin : g_lut
        localparam logic [pcc_pkg::COST_W-1:0] ENTRY = exp_entry(64'(g));
        assign lut[g] = ENTRY;
    end

    logic [PROD_W-1:0] prod_reg;
    logic [SCALED_W-1:0] scaled_next;
    logic [IDX_W-1:0] idx_reg;
    logic oob_reg;
    logic [pcc_pkg::COST_W-1:0] val_reg;

    assign scaled_next = ((SCALED_W'(prod_reg) * ENTRIES) + HALF_STEP) >> 24;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(distance) * PROD_W'(rate);
            idx_reg <= scaled_next[IDX_W-1:0];
            oob_reg <= (scaled_next >= ENTRIES);
            val_reg <= oob_reg ? '0 : lut[idx_reg];
        end
    end

    assign exp_val = val_reg;

endmodule

// ===== hw/rtl/pcc_mix.sv =====
module pcc_mix (
    input  logic                            clk,
    input  logic                            en,
    input  pcc_pkg::cfg_t                   cfg,
    input  logic [pcc_pkg::COST_W-1:0]      o_in,
    input  logic [pcc_pkg::COST_W-1:0]      v_in,
    input  logic [pcc_pkg::COST_W-1:0]      c_in,
    output logic [pcc_pkg::COST_W-1:0]      o_out,
    output logic [pcc_pkg::COST_W-1:0]      v_out,
    output logic [pcc_pkg::COST_W-1:0]      c_out,
    output logic [pcc_pkg::COST_W-1:0]      comb_out,
    output logic [pcc_pkg::COST_W-1:0]      prob_out
);

    localparam int unsigned W = pcc_pkg::COST_W;

    logic [W-1:0] o5_reg, v5_reg, c5_reg;
    logic [2*W-1:0] wo_reg, wv_reg, wc_reg;
    logic [2*W-1:0] cpvp_reg;
    logic near5_reg;

    logic [W-1:0] o6_reg, v6_reg, c6_reg, comb6_reg, s6_reg, inv6_reg;
    logic [2*W+1:0] sum_next;
    logic [2*W-15:0] comb_next;
    logic [W:0] s_next;
    logic [W-1:0] cp6, vp6;

    logic [W-1:0] o7_reg, v7_reg, c7_reg, comb7_reg;
    logic [2*W-1:0] p7_reg;
    logic [2*W:0] p_round;

    logic [W-1:0] o8_reg, v8_reg, c8_reg, comb8_reg, p8_reg;

    assign sum_next = (2*W+2)'(wo_reg) + (2*W+2)'(wv_reg) + (2*W+2)'(wc_reg) + (2*W+2)'(32768);
    assign comb_next = sum_next[2*W+1:16];
    assign cp6 = pcc_pkg::COST_ONE - c5_reg;
    assign vp6 = pcc_pkg::COST_ONE - v5_reg;
    assign s_next = (W+1)'(cp6) + (W+1)'(vp6)
                    - (W+1)'(((2*W+1)'(cpvp_reg) + (2*W+1)'(32768)) >> 16);
    assign p_round = ((2*W+1)'(p7_reg) + (2*W+1)'(32768)) >> 16;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o5_reg <= o_in;
            v5_reg <= v_in;
            c5_reg <= c_in;
            wo_reg <= (2*W)'(cfg.obstacle_weight) * (2*W)'(o_in);
            wv_reg <= (2*W)'(cfg.view_weight) * (2*W)'(v_in);
            wc_reg <= (2*W)'(cfg.center_weight) * (2*W)'(c_in);
            cpvp_reg <= (2*W)'(pcc_pkg::COST_ONE - c_in) * (2*W)'(pcc_pkg::COST_ONE - v_in);
            near5_reg <= (o_in >= pcc_pkg::COST_NEAR_ONE);

            o6_reg <= o5_reg;
            v6_reg <= v5_reg;
            c6_reg <= c5_reg;
            if (near5_reg || (comb_next > (2*W-14)'(pcc_pkg::COST_ONE)))
                comb6_reg <= pcc_pkg::COST_ONE;
            else
                comb6_reg <= comb_next[W-1:0];
            s6_reg <= s_next[W-1:0];
            inv6_reg <= pcc_pkg::COST_ONE - o5_reg;

            o7_reg <= o6_reg;
            v7_reg <= v6_reg;
            c7_reg <= c6_reg;
            comb7_reg <= comb6_reg;
            p7_reg <= (2*W)'(inv6_reg) * (2*W)'(s6_reg);

            o8_reg <= o7_reg;
            v8_reg <= v7_reg;
            c8_reg <= c7_reg;
            comb8_reg <= comb7_reg;
            if (p_round > (2*W+1)'(pcc_pkg::COST_ONE))
                p8_reg <= pcc_pkg::COST_ONE;
            else
                p8_reg <= p_round[W-1:0];
        end
    end

    assign o_out = o8_reg;
    assign v_out = v8_reg;
    assign c_out = c8_reg;
    assign comb_out = comb8_reg;
    assign prob_out = p8_reg;

endmodule

// ===== hw/rtl/pixel_cost_combiner.sv =====
// Cost terms for a stream of map cells, one request per cell.
// The pixel channel carries a cell's occupancy byte and its distances to the
// nearest obstacle and to the skeleton; the cost channel returns obstacle,
// view, center and combined costs and a probability, all Q1.16.
// The user must write the registers through wr_en, wr_index and wr_data only
// while no request is in flight; the block itself does not enforce this.
// A request passes eight register stages before its result appears on the
// cost channel, where it stays until the receiver takes it.
// A new request is accepted every cycle unless the receiver stalls; the stages all advance together.
// Each exponential is one read of a constant table built at elaboration.
// Reset clears the pipeline valid bits and loads the register defaults.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and pixel.ready drops; nothing is lost or repeated.
module pixel_cost_combiner #(
    parameter int unsigned EXP_TABLE_ENTRIES = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [pcc_pkg::CFG_INDEX_W-1:0]     wr_index,
    input  logic [pcc_pkg::CFG_DATA_W-1:0]      wr_data,
    pcc_pixel_if.sink                           pixel,
    pcc_cost_if.source                          cost
);

    localparam int unsigned STAGES = 8;
    localparam int unsigned W = pcc_pkg::COST_W;

    pcc_pkg::cfg_t cfg;
    logic en;
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;

    logic force1_reg, force2_reg, force3_reg, force4_reg;
    logic [pcc_pkg::DIST_W-1:0] od1_reg, dv1_reg, sd1_reg;
    logic [W-1:0] eo, ev, ec, o4, v4, c4;

    pcc_cfg_regs u_cfg (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_index(wr_index),
        .wr_data(wr_data), .cfg(cfg)
    );

    assign en = !valid_reg[STAGES-1] || cost.ready;
    assign pixel.ready = en;
    assign valid_next = {valid_reg[STAGES-2:0], pixel.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            force1_reg <= (pixel.occupancy != pcc_pkg::OCC_FREE)
                          || (pixel.obstacle_distance < cfg.min_obstacle_distance);
            od1_reg <= pixel.obstacle_distance - cfg.min_obstacle_distance;
            if (pixel.obstacle_distance >= cfg.optimal_view_distance)
                dv1_reg <= pixel.obstacle_distance - cfg.optimal_view_distance;
            else
                dv1_reg <= cfg.optimal_view_distance - pixel.obstacle_distance;
            sd1_reg <= pixel.skeleton_distance;
            force2_reg <= force1_reg;
            force3_reg <= force2_reg;
            force4_reg <= force3_reg;
        end
    end

    pcc_exp_unit #(.EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES)) u_exp_obstacle (
        .clk(clk), .en(en), .distance(od1_reg), .rate(cfg.obstacle_scaling), .exp_val(eo)
    );

    pcc_exp_unit #(.EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES)) u_exp_view (
        .clk(clk), .en(en), .distance(dv1_reg), .rate(cfg.view_scaling), .exp_val(ev)
    );

    pcc_exp_unit #(.EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES)) u_exp_center (
        .clk(clk), .en(en), .distance(sd1_reg), .rate(cfg.center_scaling), .exp_val(ec)
    );

    assign o4 = force4_reg ? pcc_pkg::COST_ONE : eo;
    assign v4 = pcc_pkg::COST_ONE - ev;
    assign c4 = pcc_pkg::COST_ONE - ec;

    pcc_mix u_mix (
        .clk(clk), .en(en), .cfg(cfg), .o_in(o4), .v_in(v4), .c_in(c4),
        .o_out(cost.obstacle_term), .v_out(cost.view_term), .c_out(cost.center_term),
        .comb_out(cost.combined_cost), .prob_out(cost.probability)
    );

    assign cost.valid = valid_reg[STAGES-1];

    assert property (@(posedge clk) disable iff (!rst_n)
        cost.valid && (cost.obstacle_term >= pcc_pkg::COST_NEAR_ONE)
        |-> cost.combined_cost == pcc_pkg::COST_ONE)
        else $error("combined cost not forced near an obstacle");

    assert property (@(posedge clk) disable iff (!rst_n)
        cost.valid && (cost.obstacle_term == pcc_pkg::COST_ONE)
        |-> cost.probability == '0)
        else $error("probability nonzero at an obstacle");

    assert property (@(posedge clk) disable iff (!rst_n)
        cost.valid |-> (cost.probability <= pcc_pkg::COST_ONE)
        && (cost.combined_cost <= pcc_pkg::COST_ONE))
        else $error("result above 1.0");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned EXP_ENTRIES = 256;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned HOLD_CYCLES = 300;

    typedef struct packed {
        logic [pcc_pkg::COST_W-1:0] obstacle_term;
        logic [pcc_pkg::COST_W-1:0] view_term;
        logic [pcc_pkg::COST_W-1:0] center_term;
        logic [pcc_pkg::COST_W-1:0] combined_cost;
        logic [pcc_pkg::COST_W-1:0] probability;
    } cell_costs_t;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [pcc_pkg::CFG_INDEX_W-1:0] wr_index;
    logic [pcc_pkg::CFG_DATA_W-1:0] wr_data;

    pcc_pixel_if pixel_bus ();
    pcc_cost_if cost_bus ();

    pixel_cost_combiner u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .pixel    (pixel_bus),
        .cost     (cost_bus)
    );

    longint unsigned exp_table [EXP_ENTRIES];
    pcc_pkg::cfg_t cfg_shadow;
    cell_costs_t expected_costs [$];
    int error_count;
    int cells_sent;
    int cells_checked;
    int config_count;
    bit pixel_gaps_on;
    bit sink_gaps_on;
    bit hold_request;
    int hold_left;
    int sink_gap_left;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("pixel_cost_combiner test failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 70)
            return 0;
        else if (r < 95)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    // Exponential of -f for f in [0,1], Q.30, by an alternating series.
    function automatic longint unsigned exp_neg_q30(longint unsigned f);
        longint signed sum;
        longint unsigned term;
        sum = longint'(1) << 30;
        term = 64'd1 << 30;
        for (int k = 1; k <= 24; k++)
        begin
            term = ((term * f) >> 30) / k;
            if (k % 2 == 1)
                sum -= longint'(term);
            else
                sum += longint'(term);
        end
        if (sum < 0)
            sum = 0;
        return longint'(sum);
    endfunction

    task automatic build_exp_table();
        longint unsigned e1, y, n, r, v;
        e1 = exp_neg_q30(64'd1 << 30);
        for (int i = 0; i < EXP_ENTRIES; i++)
        begin
            y = (longint'(i) << 34) / EXP_ENTRIES;
            n = y >> 30;
            r = exp_neg_q30(y & ((64'd1 << 30) - 1));
            while (n > 0)
            begin
                r = (r * e1 + (64'd1 << 29)) >> 30;
                n--;
            end
            v = (r + 8192) >> 14;
            if (v > pcc_pkg::COST_ONE)
                v = pcc_pkg::COST_ONE;
            exp_table[i] = v;
        end
    endtask

    function automatic longint unsigned exp_of_product(longint unsigned x);
        longint unsigned idx;
        idx = (x * EXP_ENTRIES + (64'd1 << 23)) >> 24;
        if (idx >= EXP_ENTRIES)
            return 0;
        return exp_table[idx];
    endfunction

    function automatic cell_costs_t predict_costs(logic [pcc_pkg::OCC_W-1:0] occ,
                                                  logic [pcc_pkg::DIST_W-1:0] od,
                                                  logic [pcc_pkg::DIST_W-1:0] sd);
        longint unsigned o, v, c, comb, cp, vp, s, p, dv, one;
        cell_costs_t res;
        one = pcc_pkg::COST_ONE;
        if (occ != pcc_pkg::OCC_FREE || od < cfg_shadow.min_obstacle_distance)
            o = one;
        else
            o = exp_of_product(longint'(cfg_shadow.obstacle_scaling) *
                               longint'(od - cfg_shadow.min_obstacle_distance));
        if (od >= cfg_shadow.optimal_view_distance)
            dv = od - cfg_shadow.optimal_view_distance;
        else
            dv = cfg_shadow.optimal_view_distance - od;
        v = one - exp_of_product(longint'(cfg_shadow.view_scaling) * dv);
        c = one - exp_of_product(longint'(cfg_shadow.center_scaling) * longint'(sd));
        comb = (longint'(cfg_shadow.obstacle_weight) * o +
                longint'(cfg_shadow.view_weight) * v +
                longint'(cfg_shadow.center_weight) * c + 32768) >> 16;
        if (comb > one)
            comb = one;
        if (o >= pcc_pkg::COST_NEAR_ONE)
            comb = one;
        cp = one - c;
        vp = one - v;
        s = cp + vp - ((cp * vp + 32768) >> 16);
        p = ((one - o) * s + 32768) >> 16;
        if (p > one)
            p = one;
        res.obstacle_term = o[pcc_pkg::COST_W-1:0];
        res.view_term = v[pcc_pkg::COST_W-1:0];
        res.center_term = c[pcc_pkg::COST_W-1:0];
        res.combined_cost = comb[pcc_pkg::COST_W-1:0];
        res.probability = p[pcc_pkg::COST_W-1:0];
        return res;
    endfunction

    task automatic write_register(logic [pcc_pkg::CFG_INDEX_W-1:0] idx,
                                  logic [pcc_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        case (idx)
            pcc_pkg::REG_MIN_OBSTACLE_DISTANCE:
                cfg_shadow.min_obstacle_distance = val[pcc_pkg::DIST_W-1:0];
            pcc_pkg::REG_OBSTACLE_SCALING:
                cfg_shadow.obstacle_scaling = val[pcc_pkg::RATE_W-1:0];
            pcc_pkg::REG_OPTIMAL_VIEW_DISTANCE:
                cfg_shadow.optimal_view_distance = val[pcc_pkg::DIST_W-1:0];
            pcc_pkg::REG_VIEW_SCALING:
                cfg_shadow.view_scaling = val[pcc_pkg::RATE_W-1:0];
            pcc_pkg::REG_CENTER_SCALING:
                cfg_shadow.center_scaling = val[pcc_pkg::RATE_W-1:0];
            pcc_pkg::REG_OBSTACLE_WEIGHT:
                cfg_shadow.obstacle_weight = val;
            pcc_pkg::REG_VIEW_WEIGHT:
                cfg_shadow.view_weight = val;
            pcc_pkg::REG_CENTER_WEIGHT:
                cfg_shadow.center_weight = val;
            default: ;
        endcase
    endtask

    // Writes every register in turn; the block must be idle.
    task automatic apply_config(logic [16:0] min_d, logic [16:0] obs_s, logic [16:0] opt_d,
                                logic [16:0] view_s, logic [16:0] cen_s, logic [16:0] obs_w,
                                logic [16:0] view_w, logic [16:0] cen_w);
        write_register(pcc_pkg::REG_MIN_OBSTACLE_DISTANCE, min_d);
        write_register(pcc_pkg::REG_OBSTACLE_SCALING, obs_s);
        write_register(pcc_pkg::REG_OPTIMAL_VIEW_DISTANCE, opt_d);
        write_register(pcc_pkg::REG_VIEW_SCALING, view_s);
        write_register(pcc_pkg::REG_CENTER_SCALING, cen_s);
        write_register(pcc_pkg::REG_OBSTACLE_WEIGHT, obs_w);
        write_register(pcc_pkg::REG_VIEW_WEIGHT, view_w);
        write_register(pcc_pkg::REG_CENTER_WEIGHT, cen_w);
        @(negedge clk);
        wr_en <= 1'b0;
        config_count++;
    endtask

    task automatic send_cell(logic [pcc_pkg::OCC_W-1:0] occ, logic [pcc_pkg::DIST_W-1:0] od,
                             logic [pcc_pkg::DIST_W-1:0] sd);
        int gap;
        gap = pixel_gaps_on ? pick_gap() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            pixel_bus.valid <= 1'b0;
        end
        @(negedge clk);
        pixel_bus.valid <= 1'b1;
        pixel_bus.occupancy <= occ;
        pixel_bus.obstacle_distance <= od;
        pixel_bus.skeleton_distance <= sd;
        do
            @(posedge clk);
        while (!pixel_bus.ready);
        expected_costs.push_back(predict_costs(occ, od, sd));
        cells_sent++;
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        pixel_bus.valid <= 1'b0;
        while (expected_costs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [16:0] random_rate();
        int r;
        r = int'($urandom_range(0, 9));
        if (r == 0)
            return 17'd0;
        else if (r == 1)
            return 17'h0FFFF;
        else if (r < 7)
            return 17'($urandom_range(0, 8192));
        return 17'($urandom_range(0, 65535));
    endfunction

    function automatic logic [16:0] random_weight();
        int r;
        r = int'($urandom_range(0, 9));
        if (r == 0)
            return 17'd0;
        else if (r == 1)
            return pcc_pkg::COST_ONE;
        return 17'($urandom_range(0, 65536));
    endfunction

    function automatic logic [pcc_pkg::DIST_W-1:0] random_distance(
        logic [pcc_pkg::DIST_W-1:0] anchor);
        int r;
        int d;
        r = int'($urandom_range(0, 9));
        if (r < 4)
            return 16'($urandom_range(0, 2048));
        if (r < 8)
        begin
            d = int'(anchor) + int'($urandom_range(0, 512)) - 256;
            if (d < 0)
                d = 0;
            if (d > 65535)
                d = 65535;
            return d[pcc_pkg::DIST_W-1:0];
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic send_random_cell();
        logic [pcc_pkg::OCC_W-1:0] occ;
        int r;
        r = int'($urandom_range(0, 9));
        if (r < 7)
            occ = pcc_pkg::OCC_FREE;
        else if (r == 7)
            occ = 8'd0;
        else if (r == 8)
            occ = 8'd100;
        else
            occ = 8'($urandom_range(0, 255));
        send_cell(occ,
                  random_distance($urandom_range(0, 1) ? cfg_shadow.min_obstacle_distance
                                                       : cfg_shadow.optimal_view_distance),
                  random_distance(16'd0));
    endtask

    task automatic test_directed();
        send_cell(pcc_pkg::OCC_FREE, 0, 0);
        send_cell(0, 0, 0);
        send_cell(100, 512, 512);
        send_cell(254, 300, 300);
        send_cell(pcc_pkg::OCC_FREE, 16'hFFFF, 16'hFFFF);
        send_cell(pcc_pkg::OCC_FREE, 256, 256);
        send_cell(pcc_pkg::OCC_FREE, 128, 4095);
        send_cell(pcc_pkg::OCC_FREE, 4096, 4095);
        send_cell(pcc_pkg::OCC_FREE, 4097, 4097);
        send_cell(pcc_pkg::OCC_FREE, 16'h5555, 16'hAAAA);
        wait_for_drain();
        apply_config(1024, 4096, 2048, 8192, 2048, 30000, 20000, 15536);
        send_cell(pcc_pkg::OCC_FREE, 1023, 0);
        send_cell(pcc_pkg::OCC_FREE, 1024, 1);
        send_cell(pcc_pkg::OCC_FREE, 1025, 2);
        send_cell(pcc_pkg::OCC_FREE, 2048, 100);
        send_cell(pcc_pkg::OCC_FREE, 1500, 8000);
        send_cell(8'h7F, 3000, 16'hFFFF);
        wait_for_drain();
    endtask

    task automatic test_config_extremes();
        apply_config(0, 0, 0, 0, 0, 0, 0, 0);
        send_cell(pcc_pkg::OCC_FREE, 0, 0);
        send_cell(pcc_pkg::OCC_FREE, 16'hFFFF, 16'hFFFF);
        send_cell(0, 1000, 1000);
        wait_for_drain();
        apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        send_cell(pcc_pkg::OCC_FREE, 16'hFFFF, 16'hFFFF);
        send_cell(pcc_pkg::OCC_FREE, 16'hFFFE, 1);
        send_cell(pcc_pkg::OCC_FREE, 0, 0);
        wait_for_drain();
        apply_config(0, 16'hFFFF, 0, 1, 16'hFFFF, pcc_pkg::COST_ONE, pcc_pkg::COST_ONE,
                     pcc_pkg::COST_ONE);
        send_cell(pcc_pkg::OCC_FREE, 0, 0);
        send_cell(pcc_pkg::OCC_FREE, 1, 1);
        send_cell(pcc_pkg::OCC_FREE, 16'hFFFF, 16'hFFFF);
        wait_for_drain();
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 8; phase++)
        begin
            apply_config(($urandom_range(0, 1) ? 17'($urandom_range(0, 1024))
                                                : 17'($urandom_range(0, 65535))),
                         random_rate(), 17'($urandom_range(0, 2048)), random_rate(),
                         random_rate(), random_weight(), random_weight(), random_weight());
            pixel_gaps_on = (phase % 3) != 2;
            sink_gaps_on = (phase % 4) != 3;
            repeat (170) send_random_cell();
            wait_for_drain();
        end
        pixel_gaps_on = 1'b1;
        sink_gaps_on = 1'b1;
    endtask

    task automatic test_backpressure();
        pixel_gaps_on = 1'b0;
        hold_request = 1'b1;
        repeat (120) send_random_cell();
        wait_for_drain();
        pixel_gaps_on = 1'b1;
    endtask

    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            cost_bus.ready <= 1'b0;
        end
        else if (!sink_gaps_on)
            cost_bus.ready <= 1'b1;
        else if (sink_gap_left > 0)
        begin
            sink_gap_left--;
            cost_bus.ready <= 1'b0;
        end
        else
        begin
            cost_bus.ready <= 1'b1;
            sink_gap_left = pick_gap();
        end
    end

    task automatic compare_field(string name, logic [pcc_pkg::COST_W-1:0] exp_v,
                                 logic [pcc_pkg::COST_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        cell_costs_t want;
        if (rst_n && cost_bus.valid && cost_bus.ready)
        begin
            if (expected_costs.size() == 0)
            begin
                $error("unexpected result on the cost channel");
                error_count++;
            end
            else
            begin
                want = expected_costs.pop_front();
                compare_field("obstacle_term", want.obstacle_term, cost_bus.obstacle_term);
                compare_field("view_term", want.view_term, cost_bus.view_term);
                compare_field("center_term", want.center_term, cost_bus.center_term);
                compare_field("combined_cost", want.combined_cost, cost_bus.combined_cost);
                compare_field("probability", want.probability, cost_bus.probability);
                cells_checked++;
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        pixel_bus.valid = 1'b0;
        pixel_bus.occupancy = '0;
        pixel_bus.obstacle_distance = '0;
        pixel_bus.skeleton_distance = '0;
        cost_bus.ready = 1'b0;
        error_count = 0;
        cells_sent = 0;
        cells_checked = 0;
        config_count = 0;
        pixel_gaps_on = 1'b1;
        sink_gaps_on = 1'b1;
        hold_request = 1'b0;
        hold_left = 0;
        sink_gap_left = 0;
        cfg_shadow.min_obstacle_distance = 16'd0;
        cfg_shadow.obstacle_scaling = 16'd4096;
        cfg_shadow.optimal_view_distance = 16'd256;
        cfg_shadow.view_scaling = 16'd4096;
        cfg_shadow.center_scaling = 16'd4096;
        cfg_shadow.obstacle_weight = 17'd21845;
        cfg_shadow.view_weight = 17'd21845;
        cfg_shadow.center_weight = 17'd21846;
        build_exp_table();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random_phases();
        test_backpressure();

        $display("Sent %0d cells and checked %0d results under %0d register settings,",
                 cells_sent, cells_checked, config_count);
        $display("including a long output stall that filled the pipeline.");
        if (error_count == 0 && expected_costs.size() == 0)
            $display("pixel_cost_combiner test passed");
        else
            $display("pixel_cost_combiner test failed");
        $finish;
    end

endmodule
